// File: hdl/swpr_pkg.sv
// Shared types and constants for the sliding-window peak rate core.
// No dependencies; every module of the core imports this package.
package swpr_pkg;

    // Status codes from 500 to 599 count as server errors.
    localparam logic [9:0]  ERR_STATUS_LO = 10'd500;
    localparam logic [9:0]  ERR_STATUS_HI = 10'd599;

    // Reset value of the window length register, in seconds.
    localparam logic [31:0] WINDOW_RESET  = 32'd10;

    // Width of the count fields on the result port.
    localparam int OUT_COUNT_W = 11;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // One classified request as it travels from the front to the back end.
    typedef struct packed {
        logic [31:0] timestamp;
        logic        is_error;
    } t_item;

    // One result as it leaves the back end.
    typedef struct packed {
        logic [OUT_COUNT_W-1:0] window_count;
        logic [OUT_COUNT_W-1:0] peak_count;
        logic [31:0]            peak_first_time;
        logic [31:0]            peak_last_time;
        logic [31:0]            error_total;
        logic                   overflowed;
    } t_result;

endpackage

// File: hdl/swpr_front.sv
// Front end of the sliding-window peak rate core: accepts requests and classifies their status.
// Depends on swpr_pkg for the status bounds and the item type.
module swpr_front
    import swpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_timestamp_seconds,
    input  logic [9:0]  i_status_code,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_q_ready
);

    logic  r_valid;
    t_item r_item;
    logic  in_take;

    // The stage takes a new transaction when it is empty or hands its item on this cycle.
    assign o_in_ready = !r_valid || i_q_ready;
    assign in_take    = i_in_valid && o_in_ready;

    // Valid flag of the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_take) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the timestamp and flag a 5xx status.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.timestamp <= i_timestamp_seconds;
            r_item.is_error  <= (i_status_code >= ERR_STATUS_LO) &&
                                (i_status_code <= ERR_STATUS_HI);
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;

endmodule

// File: hdl/swpr_queue.sv
// Short first-in first-out queue of classified requests between the front and back ends.
// Depends on swpr_pkg for the item type and the queue size.
module swpr_queue
    import swpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// File: hdl/swpr_back.sv
// Back end of the sliding-window peak rate core: timestamp ring, window trimming,
// peak and error bookkeeping, and the result register. Depends on swpr_pkg.
module swpr_back
    import swpr_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_window,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;

    // Timestamp ring memory and its registered read data.
    logic [31:0]   r_ring [RING_DEPTH];
    logic [31:0]   r_rd_data;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic [31:0]   r_ts;
    logic          r_err;
    logic [CW-1:0] r_best_count;
    logic [31:0]   r_best_from;
    logic [31:0]   r_best_to;
    logic [31:0]   r_err_total;
    logic          r_out_valid;
    t_result       r_result;

    logic [AW-1:0] head_inc;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          ring_we;
    logic          full;
    logic [31:0]   span;
    logic          pop;
    logic          out_free;
    logic          finish;
    logic          take;
    logic          new_peak;
    logic [CW-1:0] best_count_nx;
    logic [31:0]   best_from_nx;
    logic [31:0]   best_to_nx;
    logic [31:0]   err_total_nx;
    logic [31:0]   oldest;
    logic [CW+OUT_COUNT_W-1:0] fill_ext;
    logic [CW+OUT_COUNT_W-1:0] best_ext;

    // Ring index arithmetic: successor of the head and the slot after the newest entry.
    assign head_inc = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_sum = {1'b0, r_head} + (AW + 1)'(r_fill);
    assign wr_addr  = (tail_sum >= (AW + 1)'(RING_DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(RING_DEPTH)) : tail_sum[AW-1:0];
    assign full     = (r_fill == CW'(RING_DEPTH));

    // Drop the oldest entry while its distance to the newest exceeds the window.
    assign span     = r_ts - r_rd_data;
    assign pop      = (r_state == ST_CHECK) && (r_fill > CW'(1)) && (span > i_window);
    assign out_free = !r_out_valid || i_out_ready;
    assign finish   = (r_state == ST_CHECK) && !pop && out_free;
    assign o_q_ready = (r_state == ST_IDLE) || finish;
    assign take     = i_q_valid && o_q_ready;

    // Sequencer: a push state, then a check state that drops entries one at a time.
    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        rd_addr = r_head;
        ring_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = r_head;
            end
            ST_WRITE: begin
                ring_we = 1'b1;
                n_ovf   = full;
                n_head  = full ? head_inc : r_head;
                n_fill  = full ? r_fill : r_fill + 1'b1;
                rd_addr = n_head;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (pop) begin
                    n_head  = head_inc;
                    n_fill  = r_fill - 1'b1;
                    rd_addr = head_inc;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (take) begin
            n_state = ST_WRITE;
        end
    end

    // Ring memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[wr_addr] <= r_ts;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // With a single kept entry the oldest is the newest; the memory read is not used then.
    assign oldest        = (r_fill == CW'(1)) ? r_ts : r_rd_data;
    assign new_peak      = (r_fill > r_best_count);
    assign best_count_nx = new_peak ? r_fill : r_best_count;
    assign best_from_nx  = new_peak ? oldest : r_best_from;
    assign best_to_nx    = new_peak ? r_ts : r_best_to;
    assign err_total_nx  = (r_err && (r_err_total != '1)) ? r_err_total + 1'b1 : r_err_total;
    assign fill_ext      = {{OUT_COUNT_W{1'b0}}, r_fill};
    assign best_ext      = {{OUT_COUNT_W{1'b0}}, best_count_nx};

    // Control state and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_fill       <= '0;
            r_ovf        <= 1'b0;
            r_best_count <= '0;
            r_best_from  <= '0;
            r_best_to    <= '0;
            r_err_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            if (finish) begin
                r_best_count <= best_count_nx;
                r_best_from  <= best_from_nx;
                r_best_to    <= best_to_nx;
                r_err_total  <= err_total_nx;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Current request and result payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ts  <= i_q_item.timestamp;
            r_err <= i_q_item.is_error;
        end
        if (finish) begin
            r_result.window_count    <= fill_ext[OUT_COUNT_W-1:0];
            r_result.peak_count      <= best_ext[OUT_COUNT_W-1:0];
            r_result.peak_first_time <= best_from_nx;
            r_result.peak_last_time  <= best_to_nx;
            r_result.error_total     <= err_total_nx;
            r_result.overflowed      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // The ring never holds more entries than it has slots.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(RING_DEPTH))
        else $error("ring fill exceeds depth");

    // A push cycle is always followed by a check cycle.
    a_write_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_state == ST_CHECK))
        else $error("push not followed by check");

    // Trimming never empties the window: the newest entry always stays.
    a_check_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_fill != '0))
        else $error("window empty while checking");

    // Each drop removes exactly one entry.
    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("drop did not remove one entry");

    // After a result the peak is at least the current window count.
    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_best_count >= r_fill))
        else $error("peak below window count");

endmodule

// File: hdl/sliding_window_peak_rate_core.sv
// Top level of the sliding-window peak rate core: window register, front end, queue, back end.
// Depends on swpr_pkg, swpr_front, swpr_queue and swpr_back.
//
//   Channel  | Signals                                         | Direction
//   ---------+-------------------------------------------------+----------
//   request  | i_in_valid/o_in_ready, timestamp, status code   | in
//   result   | o_out_valid/i_out_ready, counts, peak, errors   | out
//   config   | i_cfg_valid/o_cfg_ready, i_cfg_window_seconds   | in
//
// In the back end each request passes a push state, then a check state that drops at
// most one timestamp from the window per visit; the single read port of the timestamp
// ring memory sets this. Each entry drops from the ring at most once.
// Reset is synchronous and active low; the ring contents need no clearing after reset.
// A stalled result port holds the back end at the end of its work, while the input stage
// and the two-entry queue keep taking requests.
module sliding_window_peak_rate_core
    import swpr_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [31:0]            i_timestamp_seconds,
    input  logic [9:0]             i_status_code,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_COUNT_W-1:0] o_window_count,
    output logic [OUT_COUNT_W-1:0] o_peak_count,
    output logic [31:0]            o_peak_first_time,
    output logic [31:0]            o_peak_last_time,
    output logic [31:0]            o_error_total,
    output logic                   o_overflowed,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [31:0]            i_cfg_window_seconds
);

    logic [31:0] r_window;
    logic        front_push;
    t_item       front_item;
    logic        q_ready;
    logic        q_valid;
    t_item       q_item;
    logic        back_ready;
    t_result     back_result;

    // Window length register; every configuration transaction is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_window_seconds;
        end
    end

    // Request intake and status classification.
    swpr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_timestamp_seconds (i_timestamp_seconds),
        .i_status_code       (i_status_code),
        .o_push              (front_push),
        .o_item              (front_item),
        .i_q_ready           (q_ready)
    );

    // Decoupling queue.
    swpr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_push_item (front_item),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_pop       (back_ready)
    );

    // Ring, window trimming and result generation.
    swpr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_window),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_ready   (back_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (back_result)
    );

    assign o_window_count    = back_result.window_count;
    assign o_peak_count      = back_result.peak_count;
    assign o_peak_first_time = back_result.peak_first_time;
    assign o_peak_last_time  = back_result.peak_last_time;
    assign o_error_total     = back_result.error_total;
    assign o_overflowed      = back_result.overflowed;

endmodule

// File: test/tb.sv
// Self-checking testbench for sliding_window_peak_rate_core, with a request stream and backpressure.
// Depends on swpr_pkg and the core RTL; an in-line tracker class predicts every result.
`timescale 1ns / 100ps

module tb
    import swpr_pkg::*;
();

    localparam int RING_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [31:0]            i_timestamp_seconds;
    logic [9:0]             i_status_code;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [OUT_COUNT_W-1:0] o_window_count;
    logic [OUT_COUNT_W-1:0] o_peak_count;
    logic [31:0]            o_peak_first_time;
    logic [31:0]            o_peak_last_time;
    logic [31:0]            o_error_total;
    logic                   o_overflowed;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [31:0]            i_cfg_window_seconds;

    // Receiver stall patterns.
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_MOSTLY} t_sink_mode;

    // Tracks the timestamp ring, peak and error tally, and queues the expected results.
    class t_peak_rate_tracker;
        logic [31:0] stamps [RING_DEPTH];
        int          oldest;
        int          kept;
        int          best_kept;
        logic [31:0] best_first;
        logic [31:0] best_last;
        logic [31:0] error_tally;
        logic [31:0] window;
        t_result     expected_results [$];
        int          fail_count;

        function new();
            oldest      = 0;
            kept        = 0;
            best_kept   = 0;
            best_first  = '0;
            best_last   = '0;
            error_tally = '0;
            window      = WINDOW_RESET;
            fail_count  = 0;
        endfunction

        function void set_window(logic [31:0] value);
            window = value;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [31:0] stamp, logic [9:0] status);
            t_result     r;
            logic [31:0] span;
            r.overflowed = 1'b0;
            // A full ring loses its oldest entry before the new one goes in.
            if (kept >= RING_DEPTH) begin
                oldest = (oldest + 1) % RING_DEPTH;
                kept--;
                r.overflowed = 1'b1;
            end
            stamps[(oldest + kept) % RING_DEPTH] = stamp;
            kept++;
            // Trim from the old end while the modular span is too wide.
            span = stamp - stamps[oldest];
            while (kept > 1 && span > window) begin
                oldest = (oldest + 1) % RING_DEPTH;
                kept--;
                span = stamp - stamps[oldest];
            end
            if (status >= ERR_STATUS_LO && status <= ERR_STATUS_HI && error_tally != '1)
                error_tally++;
            // Only a strictly larger window replaces the peak.
            if (kept > best_kept) begin
                best_kept  = kept;
                best_first = stamps[oldest];
                best_last  = stamp;
            end
            r.window_count    = OUT_COUNT_W'(kept);
            r.peak_count      = OUT_COUNT_W'(best_kept);
            r.peak_first_time = best_first;
            r.peak_last_time  = best_last;
            r.error_total     = error_tally;
            expected_results.push_back(r);
        endfunction

        // Compare one result transaction with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("Result with no request pending: window_count %0d", got.window_count);
                fail_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.window_count !== want.window_count) begin
                $error("window_count: expected %0d, got %0d", want.window_count,
                       got.window_count);
                fail_count++;
            end
            if (got.peak_count !== want.peak_count) begin
                $error("peak_count: expected %0d, got %0d", want.peak_count, got.peak_count);
                fail_count++;
            end
            if (got.peak_first_time !== want.peak_first_time) begin
                $error("peak_first_time: expected %h, got %h", want.peak_first_time,
                       got.peak_first_time);
                fail_count++;
            end
            if (got.peak_last_time !== want.peak_last_time) begin
                $error("peak_last_time: expected %h, got %h", want.peak_last_time,
                       got.peak_last_time);
                fail_count++;
            end
            if (got.error_total !== want.error_total) begin
                $error("error_total: expected %0d, got %0d", want.error_total,
                       got.error_total);
                fail_count++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
                fail_count++;
            end
        endfunction
    endclass

    t_peak_rate_tracker tracker;
    int                 burst_left;
    logic [31:0]        stamp_cursor;
    bit                 hold_request;

    sliding_window_peak_rate_core #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_timestamp_seconds (i_timestamp_seconds),
        .i_status_code       (i_status_code),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_window_count      (o_window_count),
        .o_peak_count        (o_peak_count),
        .o_peak_first_time   (o_peak_first_time),
        .o_peak_last_time    (o_peak_last_time),
        .o_error_total       (o_error_total),
        .o_overflowed        (o_overflowed),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_seconds(i_cfg_window_seconds)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Record accepted requests and check accepted results at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_result seen;
        if (i_rst_n === 1'b1 && i_in_valid && o_in_ready === 1'b1)
            tracker.note_request(i_timestamp_seconds, i_status_code);
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            seen.window_count    = o_window_count;
            seen.peak_count      = o_peak_count;
            seen.peak_first_time = o_peak_first_time;
            seen.peak_last_time  = o_peak_last_time;
            seen.error_total     = o_error_total;
            seen.overflowed      = o_overflowed;
            tracker.check_result(seen);
        end
    end

    // Result receiver: switches between stall patterns and honors one long hold-off request.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        int         sink_cycle;
        mode        = SINK_OPEN;
        mode_left   = 0;
        hold_left   = 0;
        sink_cycle  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            sink_cycle++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   i_out_ready <= 1'b1;
                    SINK_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    SINK_COMB:   i_out_ready <= (sink_cycle % 4) != 3;
                    default:     i_out_ready <= $urandom_range(0, 9) < 8;
                endcase
            end
        end
    end

    // Offer one request and hold it until accepted; a burst may be followed by a gap.
    task automatic offer_request(input logic [31:0] stamp, input logic [9:0] status);
        int gap;
        i_in_valid          <= 1'b1;
        i_timestamp_seconds <= stamp;
        i_status_code       <= status;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the window register with the block idle.
    task automatic write_window(input logic [31:0] value);
        wait_for_results();
        i_cfg_valid          <= 1'b1;
        i_cfg_window_seconds <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_window(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small forward steps, with some backward steps, jumps and fully random stamps.
    function automatic logic [31:0] next_stamp(input int unsigned step_max);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            stamp_cursor += $urandom_range(0, step_max);
        else if (pick < 86)
            stamp_cursor -= $urandom_range(1, 2 * step_max + 1);
        else if (pick < 93)
            stamp_cursor += $urandom_range(step_max + 1, 20 * step_max + 20);
        else
            stamp_cursor = $urandom();
        return stamp_cursor;
    endfunction

    // Status codes weighted toward the error band and its edges.
    function automatic logic [9:0] next_status();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 10'($urandom_range(ERR_STATUS_LO, ERR_STATUS_HI));
        if (pick < 45) begin
            case ($urandom_range(0, 3))
                0:       return ERR_STATUS_LO - 10'd1;
                1:       return ERR_STATUS_LO;
                2:       return ERR_STATUS_HI;
                default: return ERR_STATUS_HI + 10'd1;
            endcase
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    // One stretch of random requests, optionally pausing halfway until all results are in.
    task automatic run_requests(input int count, input int unsigned step_max,
                                input bit pause_midway);
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2)
                wait_for_results();
            offer_request(next_stamp(step_max), next_status());
        end
    endtask

    // Run limit.
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial begin : stimulus
        tracker              = new();
        burst_left           = 4;
        stamp_cursor         = 32'd1000;
        hold_request         = 1'b0;
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_timestamp_seconds  = '0;
        i_status_code        = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_window_seconds = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests under the reset window of 10 seconds. The error tally
        // saturation point lies far beyond any practical run length.
        offer_request(32'd0, 10'd0);
        offer_request(32'd5, ERR_STATUS_LO - 10'd1);
        offer_request(32'd10, ERR_STATUS_LO);          // span exactly equal to the window
        offer_request(32'd11, ERR_STATUS_HI);          // one dropped, count equals the peak
        offer_request(32'd12, ERR_STATUS_HI + 10'd1);
        offer_request(32'd12, 10'd999);
        offer_request(32'd13, 10'd1023);
        offer_request(32'hFFFF_FFFF, 10'd598);         // far ahead leaves only itself in the window
        offer_request(32'd0, 10'd501);                 // wraps forward by one second
        offer_request(32'd3, 10'd0);
        offer_request(32'd1, 10'd550);                 // slightly backward, still in range
        offer_request(32'h8000_0000, 10'd700);
        offer_request(32'h7FFF_FFFF, ERR_STATUS_LO);   // backward step looks far away
        offer_request(32'hAAAA_AAAA, 10'd555);
        offer_request(32'h5555_5555, 10'd444);
        offer_request(32'h5555_5555, 10'd512);

        // Reset window with a long receiver hold-off so the input side backs up.
        hold_request = 1'b1;
        run_requests(60, 4, 1'b1);

        write_window(32'd0);
        run_requests(40, 1, 1'b0);

        write_window(32'd1);
        run_requests(40, 2, 1'b0);

        write_window(32'($urandom_range(2, 60)));
        run_requests(40, 8, 1'b0);

        // Widest window: nothing ages out, so the ring fills and starts overflowing.
        write_window(32'hFFFF_FFFF);
        run_requests(1040, 3, 1'b0);

        // Back to the reset value: the first request trims a full ring.
        write_window(WINDOW_RESET);
        run_requests(20, 4, 1'b0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (tracker.fail_count == 0 && tracker.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
